[rtl/pefr_pkg.sv]
// ----------------------------------------------------------------------------
// pefr_pkg: shared types and constants of the element replicate fill block
// Payload structs, register indexes and the segment control group that the
// sequencer hands to the shift unit.
// ----------------------------------------------------------------------------
package pefr_pkg;

    localparam int WORD_BITS     = 64;
    localparam int MAX_WORDS_DEF = 64;
    localparam int OUT_WORDS     = 64;
    localparam int CFG_W         = 13;
    localparam int CFG_IDX_W     = 4;
    localparam int OFS_W         = 6;   // bit offset inside one word
    localparam int LEN_W         = 7;   // segment length, 1 to 64
    localparam int POS_W         = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_WIDTH     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_WIDTH   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_TOTAL   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_PRESENT = 4'd3;

    typedef struct packed {
        logic [WORD_BITS-1:0] pattern_value_word;
        logic [WORD_BITS-1:0] pattern_unknown_word;
        logic                 pattern_last;
    } t_in_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] fill_value_word;
        logic [WORD_BITS-1:0] fill_unknown_word;
        logic [POS_W-1:0]     word_position;
        logic                 fill_last;
    } t_out_item;

    // One segment move: source offset, destination offset, length, gating
    typedef struct packed {
        logic [OFS_W-1:0] src_ofs;
        logic [OFS_W-1:0] dst_ofs;
        logic [LEN_W-1:0] len;
        logic             src_zero;
        logic             unk_en;
    } t_seg_ctrl;

endpackage

[rtl/packed_element_replicate_fill_top.sv]
// ----------------------------------------------------------------------------
// packed_element_replicate_fill_top: element replicate fill
// Loading accepts source words back to back; a last word leads to a setup state,
// then each destination word is built segment by segment (store read, then
// shift and merge) and is held until transferred.
// About 64/element_width + 2 segments per word at most, none past the fill end.
// The input is not ready until the top word transfers, or setup ends with no words.
// Synchronous active-low reset clears control, sets registers to defaults; store and accumulators undefined.
// ----------------------------------------------------------------------------
module packed_element_replicate_fill_top #(
    parameter int MAX_WORDS = pefr_pkg::MAX_WORDS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pefr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pefr_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  pefr_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output pefr_pkg::t_out_item             o_out_data
);

    localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int LW  = $clog2(MAX_WORDS + 1);
    localparam int CW  = pefr_pkg::CFG_W;
    localparam int WB  = pefr_pkg::WORD_BITS;
    localparam int WIX = CW - pefr_pkg::OFS_W;     // word index bits of j
    localparam int NW  = pefr_pkg::LEN_W;          // destination word count bits
    localparam logic [CW-1:0] TW_MAX = CW'(pefr_pkg::OUT_WORDS * WB);
    localparam logic [pefr_pkg::LEN_W-1:0] FULL = pefr_pkg::LEN_W'(WB);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_SETUP = 5'b00010,
        S_ADDR  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state                     r_state;
    logic [CW-1:0]              r_total_width;
    logic [CW-1:0]              r_element_width;
    logic [CW-1:0]              r_element_total;
    logic                       r_unknown_present;
    logic [LW-1:0]              r_words_loaded;
    logic [CW-1:0]              r_fill_end;
    logic [NW-1:0]              r_nwords;
    logic [NW-1:0]              r_word;
    logic [pefr_pkg::LEN_W-1:0] r_b;
    logic [CW-1:0]              r_k;
    logic [CW-1:0]              r_j;
    logic [pefr_pkg::LEN_W-1:0] r_len;
    logic                       r_oor;
    logic [WB-1:0]              r_acc_v;
    logic [WB-1:0]              r_acc_u;

    logic                       in_xfer;
    logic                       out_xfer;
    logic                       store_we;
    logic [AW-1:0]              raddr;
    logic [WIX-1:0]             widx;
    logic [WB-1:0]              rvalue;
    logic [WB-1:0]              runknown;
    logic [WB-1:0]              seg_v;
    logic [WB-1:0]              seg_u;
    pefr_pkg::t_seg_ctrl        seg_ctrl;
    logic [2*CW-1:0]            product;
    logic [CW-1:0]              tw_sat;
    logic [CW-1:0]              fill_end;
    logic [CW:0]                tw_round;
    logic [CW-1:0]              len_src;
    logic [CW-1:0]              len_elem;
    logic [CW-1:0]              len_dst;
    logic [CW-1:0]              len_fill;
    logic [CW-1:0]              len_min;
    logic [CW-1:0]              j_next;
    logic                       word_done;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_EMIT);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_xfer    = o_out_valid && i_out_ready;
    assign store_we    = in_xfer && (int'(r_words_loaded) < MAX_WORDS);

    // Store word index of the current element bit
    assign widx  = r_j[CW-1:pefr_pkg::OFS_W];
    assign raddr = AW'({{AW{1'b0}}, widx});

    pefr_store #(
        .MAX_WORDS (MAX_WORDS)
    ) u_store (
        .i_clk      (i_clk),
        .i_we       (store_we),
        .i_waddr    (AW'(r_words_loaded)),
        .i_wvalue   (i_in_data.pattern_value_word),
        .i_wunknown (i_in_data.pattern_unknown_word),
        .i_raddr    (raddr),
        .o_rvalue   (rvalue),
        .o_runknown (runknown)
    );

    assign seg_ctrl.src_ofs  = r_j[pefr_pkg::OFS_W-1:0];
    assign seg_ctrl.dst_ofs  = r_b[pefr_pkg::OFS_W-1:0];
    assign seg_ctrl.len      = r_len;
    assign seg_ctrl.src_zero = r_oor;
    assign seg_ctrl.unk_en   = r_unknown_present;

    pefr_shift_unit u_shift (
        .i_ctrl        (seg_ctrl),
        .i_src_value   (rvalue),
        .i_src_unknown (runknown),
        .o_seg_value   (seg_v),
        .o_seg_unknown (seg_u)
    );

    // Fill extent and destination word count
    always_comb begin
        product  = r_element_total * r_element_width;
        tw_sat   = (r_total_width > TW_MAX) ? TW_MAX : r_total_width;
        fill_end = (product > (2*CW)'(tw_sat)) ? tw_sat : product[CW-1:0];
        tw_round = {1'b0, tw_sat} + (CW+1)'(WB - 1);
    end

    // Segment length: least of source word, element, destination word, fill
    always_comb begin
        len_src  = CW'(WB) - CW'(r_j[pefr_pkg::OFS_W-1:0]);
        len_elem = r_element_width - r_j;
        len_dst  = CW'(WB) - CW'(r_b);
        len_fill = r_fill_end - r_k;
        len_min  = len_src;
        if (len_elem < len_min) begin
            len_min = len_elem;
        end
        if (len_dst < len_min) begin
            len_min = len_dst;
        end
        if (len_fill < len_min) begin
            len_min = len_fill;
        end
        word_done = (r_b == FULL) || (r_k >= r_fill_end);
        j_next    = r_j + CW'(r_len);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_width     <= CW'(64);
            r_element_width   <= CW'(8);
            r_element_total   <= '0;
            r_unknown_present <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                pefr_pkg::CFG_TOTAL_WIDTH:     r_total_width     <= i_cfg_data;
                pefr_pkg::CFG_ELEMENT_WIDTH:   r_element_width   <= i_cfg_data;
                pefr_pkg::CFG_ELEMENT_TOTAL:   r_element_total   <= i_cfg_data;
                pefr_pkg::CFG_UNKNOWN_PRESENT: r_unknown_present <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_LOAD;
            r_words_loaded <= '0;
            r_fill_end     <= '0;
            r_nwords       <= '0;
            r_word         <= '0;
            r_b            <= '0;
            r_k            <= '0;
            r_j            <= '0;
            r_len          <= '0;
            r_oor          <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        if (store_we) begin
                            r_words_loaded <= r_words_loaded + LW'(1);
                        end
                        if (i_in_data.pattern_last) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    r_words_loaded <= '0;
                    r_fill_end     <= fill_end;
                    r_nwords       <= NW'(tw_round[CW:pefr_pkg::OFS_W]);
                    r_word         <= '0;
                    r_b            <= '0;
                    r_k            <= '0;
                    r_j            <= '0;
                    r_state <= (tw_round[CW:pefr_pkg::OFS_W] == '0) ? S_LOAD : S_ADDR;
                end
                S_ADDR: begin
                    if (word_done) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_len   <= len_min[pefr_pkg::LEN_W-1:0];
                        r_oor   <= (int'(widx) >= MAX_WORDS);
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    r_b     <= r_b + r_len;
                    r_k     <= r_k + CW'(r_len);
                    r_j     <= (j_next == r_element_width) ? '0 : j_next;
                    r_state <= S_ADDR;
                end
                S_EMIT: begin
                    if (out_xfer) begin
                        if (r_word + NW'(1) == r_nwords) begin
                            r_state <= S_LOAD;
                        end else begin
                            r_word  <= r_word + NW'(1);
                            r_b     <= '0;
                            r_state <= S_ADDR;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Accumulate destination word segments
    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP || (r_state == S_EMIT && out_xfer)) begin
            r_acc_v <= '0;
            r_acc_u <= '0;
        end else if (r_state == S_SHIFT) begin
            r_acc_v <= r_acc_v | seg_v;
            r_acc_u <= r_acc_u | seg_u;
        end
    end

    assign o_out_data.fill_value_word   = r_acc_v;
    assign o_out_data.fill_unknown_word = r_acc_u;
    assign o_out_data.word_position     = r_word[pefr_pkg::POS_W-1:0];
    assign o_out_data.fill_last         = (r_word + NW'(1) == r_nwords);

`ifndef NO_ASSERTIONS
    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    // After the top word transfers, loading resumes
    a_last_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out_data.fill_last) |=> o_in_ready)
        else $error("block not ready after top word");

    // Every segment moves between one and a full word of bits
    a_seg_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_len != '0 && r_len <= FULL))
        else $error("segment length out of range");

    // Destination offset never passes the word end
    a_dst_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |=> (r_b <= FULL))
        else $error("destination offset past word end");
`endif

endmodule

[rtl/pefr_store.sv]
// ----------------------------------------------------------------------------
// pefr_store: pattern word store
// Value and unknown planes side by side, one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module pefr_store #(
    parameter int MAX_WORDS = pefr_pkg::MAX_WORDS_DEF,
    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [AW-1:0]                  i_waddr,
    input  logic [pefr_pkg::WORD_BITS-1:0] i_wvalue,
    input  logic [pefr_pkg::WORD_BITS-1:0] i_wunknown,
    input  logic [AW-1:0]                  i_raddr,
    output logic [pefr_pkg::WORD_BITS-1:0] o_rvalue,
    output logic [pefr_pkg::WORD_BITS-1:0] o_runknown
);

    logic [2*pefr_pkg::WORD_BITS-1:0] r_mem [MAX_WORDS];
    logic [2*pefr_pkg::WORD_BITS-1:0] r_rdata;

    // Write on load, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wvalue, i_wunknown};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rvalue   = r_rdata[2*pefr_pkg::WORD_BITS-1:pefr_pkg::WORD_BITS];
    assign o_runknown = r_rdata[pefr_pkg::WORD_BITS-1:0];

endmodule

[rtl/pefr_shift_unit.sv]
// ----------------------------------------------------------------------------
// pefr_shift_unit: segment extract and place
// Takes len bits of a source word from src_ofs upward and moves them to
// dst_ofs of the destination word, for both planes.
// ----------------------------------------------------------------------------
module pefr_shift_unit (
    input  pefr_pkg::t_seg_ctrl            i_ctrl,
    input  logic [pefr_pkg::WORD_BITS-1:0] i_src_value,
    input  logic [pefr_pkg::WORD_BITS-1:0] i_src_unknown,
    output logic [pefr_pkg::WORD_BITS-1:0] o_seg_value,
    output logic [pefr_pkg::WORD_BITS-1:0] o_seg_unknown
);

    logic [pefr_pkg::WORD_BITS-1:0] mask;
    logic [pefr_pkg::WORD_BITS-1:0] src_v;
    logic [pefr_pkg::WORD_BITS-1:0] src_u;

    // Build the length mask; the top length bit means a full word
    always_comb begin
        if (i_ctrl.len[pefr_pkg::LEN_W-1]) begin
            mask = '1;
        end else begin
            mask = (pefr_pkg::WORD_BITS'(1) << i_ctrl.len[pefr_pkg::LEN_W-2:0])
                   - pefr_pkg::WORD_BITS'(1);
        end
    end

    // Drop source words that lie beyond the store; unknown bits also when not present
    assign src_v = i_ctrl.src_zero ? '0 : i_src_value;
    assign src_u = (i_ctrl.src_zero || !i_ctrl.unk_en) ? '0 : i_src_unknown;

    assign o_seg_value   = ((src_v >> i_ctrl.src_ofs) & mask) << i_ctrl.dst_ofs;
    assign o_seg_unknown = ((src_u >> i_ctrl.src_ofs) & mask) << i_ctrl.dst_ofs;

endmodule

[tb/tb_packed_element_replicate_fill_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packed_element_replicate_fill_top: self-checking bench of the fill block
// Loads element patterns word by word, predicts every destination word of the
// replicated fill in the bench and compares each transferred result field by
// field. Directed tests cover the register extremes, the clipped top word, the
// zero cases, stale and dropped store words, and one long stall; random phases
// then mix settings, pattern lengths and idle cycles on both channels.
// ----------------------------------------------------------------------------
module tb_packed_element_replicate_fill_top;

    localparam int STORE_WORDS   = pefr_pkg::MAX_WORDS_DEF;
    localparam int FILL_BITS_MAX = pefr_pkg::OUT_WORDS * pefr_pkg::WORD_BITS;
    localparam int WBITS         = pefr_pkg::WORD_BITS;
    localparam int RANDOM_ITEMS  = 240;
    // the setup state plus a segment pipe; generous for a fill with no output
    localparam int SETTLE_CYCLES = 40;
    // slowest word: one-bit elements, 64 segments per word,
    // plus the long receiver hold
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 300;
    localparam logic [pefr_pkg::CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 4'd9;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [pefr_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [pefr_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    pefr_pkg::t_in_item             i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    pefr_pkg::t_out_item            o_out_data;

    // Predictor state: pattern stores, load count and register copies
    logic [WBITS-1:0]     value_store   [STORE_WORDS];
    logic [WBITS-1:0]     unknown_store [STORE_WORDS];
    int                   words_held          = 0;
    int                   cfg_total_width     = 64;
    int                   cfg_element_width   = 8;
    int                   cfg_element_total   = 0;
    bit                   cfg_unknown_present = 1'b1;
    pefr_pkg::t_out_item  fill_words_due[$];

    // Stimulus planning: settings last written and store words ever loaded
    int plan_tw = 64;
    int plan_ew = 8;
    int plan_et = 0;
    int gen_high_water = 0;

    bit tx_burst      = 1'b0;
    bit rx_burst      = 1'b0;
    int rx_hold_cycles = 0;

    int items_sent     = 0;
    int fills_done     = 0;
    int words_checked  = 0;
    int settings_used  = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    packed_element_replicate_fill_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void apply_reg(logic [pefr_pkg::CFG_IDX_W-1:0] idx,
                                      logic [pefr_pkg::CFG_W-1:0] data);
        case (idx)
            pefr_pkg::CFG_TOTAL_WIDTH:     cfg_total_width     = int'(data);
            pefr_pkg::CFG_ELEMENT_WIDTH:   cfg_element_width   = int'(data);
            pefr_pkg::CFG_ELEMENT_TOTAL:   cfg_element_total   = int'(data);
            pefr_pkg::CFG_UNKNOWN_PRESENT: cfg_unknown_present = data[0];
            default: ;
        endcase
    endfunction

    // Store one pattern word; on the last word build every destination word
    function automatic void load_pattern_word(pefr_pkg::t_in_item word_in);
        pefr_pkg::t_out_item want;
        int tw_sat, fill_end, n_words, k, j;
        if (words_held < STORE_WORDS) begin
            value_store[words_held]   = word_in.pattern_value_word;
            unknown_store[words_held] = word_in.pattern_unknown_word;
            words_held++;
        end
        if (word_in.pattern_last) begin
            tw_sat   = (cfg_total_width > FILL_BITS_MAX) ? FILL_BITS_MAX : cfg_total_width;
            fill_end = cfg_element_total * cfg_element_width;
            if (fill_end > tw_sat) fill_end = tw_sat;
            n_words = (tw_sat + WBITS - 1) / WBITS;
            for (int w = 0; w < n_words; w++) begin
                want = '0;
                for (int b = 0; b < WBITS; b++) begin
                    k = w * WBITS + b;
                    if (k < fill_end) begin
                        j = k % cfg_element_width;
                        if (j / WBITS < STORE_WORDS) begin
                            want.fill_value_word[b] = value_store[j / WBITS][j % WBITS];
                            if (cfg_unknown_present)
                                want.fill_unknown_word[b] =
                                    unknown_store[j / WBITS][j % WBITS];
                        end
                    end
                end
                want.word_position = pefr_pkg::POS_W'(w);
                want.fill_last     = (w == n_words - 1);
                fill_words_due.push_back(want);
            end
            words_held = 0;
            fills_done++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    function automatic void check_fill_word(pefr_pkg::t_out_item got);
        pefr_pkg::t_out_item want;
        if (fill_words_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: unexpected fill word, expected none, got %h", $time, got);
            return;
        end
        want = fill_words_due.pop_front();
        words_checked++;
        compare_field("fill_value_word", want.fill_value_word, got.fill_value_word);
        compare_field("fill_unknown_word", want.fill_unknown_word, got.fill_unknown_word);
        compare_field("word_position", 64'(want.word_position), 64'(got.word_position));
        compare_field("fill_last", 64'(want.fill_last), 64'(got.fill_last));
    endfunction

    // Sample every transfer at the edge: results first, then register and
    // pattern transfers into the predictor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_fill_word(o_out_data);
            if (i_cfg_valid && o_cfg_ready) apply_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && o_in_ready) load_pattern_word(i_in_data);
        end
    end

    // Abort when no channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog, no transfer in %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: draw a hold before each result, or a long one on request
    initial begin : result_sink
        int hold;
        forever begin
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                hold = rx_burst ? 0 : $urandom_range(0, 6);
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Store words the next fill reads under the planned setting
    function automatic int words_needed();
        int tw_sat, span;
        tw_sat = (plan_tw > FILL_BITS_MAX) ? FILL_BITS_MAX : plan_tw;
        span   = plan_et * plan_ew;
        if (span > tw_sat) span = tw_sat;
        if (plan_ew < span) span = plan_ew;
        return (span + WBITS - 1) / WBITS;
    endfunction

    // Leaves valid high after the transfer; the caller drops it, as set_config does
    task automatic write_reg(logic [pefr_pkg::CFG_IDX_W-1:0] idx,
                             logic [pefr_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(int tw, int ew, int et, bit unk);
        write_reg(pefr_pkg::CFG_TOTAL_WIDTH, pefr_pkg::CFG_W'(tw));
        write_reg(pefr_pkg::CFG_ELEMENT_WIDTH, pefr_pkg::CFG_W'(ew));
        write_reg(pefr_pkg::CFG_ELEMENT_TOTAL, pefr_pkg::CFG_W'(et));
        write_reg(pefr_pkg::CFG_UNKNOWN_PRESENT, pefr_pkg::CFG_W'(unk));
        i_cfg_valid <= 1'b0;
        plan_tw = tw;
        plan_ew = ew;
        plan_et = et;
        settings_used++;
    endtask

    task automatic send_word(logic [63:0] val, logic [63:0] unk, logic last);
        pefr_pkg::t_in_item word_in;
        int gap;
        word_in.pattern_value_word   = val;
        word_in.pattern_unknown_word = unk;
        word_in.pattern_last         = last;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= word_in;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Load one random pattern; stretch it so no never-written word is read
    task automatic send_pattern(int len);
        int need;
        need = words_needed();
        if (len < need && gen_high_water < need) len = need;
        for (int i = 0; i < len; i++)
            send_word(rand_word(), rand_word(), i == len - 1);
        if (len > gen_high_water) gen_high_water = (len > STORE_WORDS) ? STORE_WORDS : len;
    endtask

    // Drop valid at the last transfer, then drain results and let the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (fill_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // zero element count after reset: one all-zero word
        send_pattern(1);
        wait_idle();
        // a write to an unused index must leave the registers alone
        write_reg(CFG_UNUSED_INDEX, pefr_pkg::CFG_W'($urandom()));
        i_cfg_valid <= 1'b0;
        send_pattern(1);
        wait_idle();
    endtask

    task automatic test_basic_replicate();
        set_config(64, 8, 8, 1'b1);
        send_word(64'h0123_4567_89ab_cdef, 64'hf0f0_0ff0_a5a5_5a5a, 1'b1);
        wait_idle();
        set_config(200, 12, 11, 1'b1);
        send_pattern(2);
        wait_idle();
    endtask

    task automatic test_top_word_clear();
        // fill clipped by total width, bits above it in the top word cleared
        set_config(70, 3, 1000, 1'b1);
        send_word('1, '1, 1'b1);
        wait_idle();
    endtask

    task automatic test_unknown_off();
        set_config(128, 5, 20, 1'b0);
        send_word('1, '1, 1'b1);
        wait_idle();
    endtask

    task automatic test_zero_cases();
        set_config(64, 0, 100, 1'b1);
        send_word('1, '1, 1'b1);
        wait_idle();
        set_config(64, 8, 0, 1'b1);
        send_word('1, '1, 1'b1);
        wait_idle();
        // no destination words at all
        set_config(0, 8, 8, 1'b1);
        send_word('1, '1, 1'b1);
        wait_idle();
    endtask

    task automatic test_oversized_width();
        set_config(8191, 64, 8191, 1'b1);
        send_pattern(2);
        wait_idle();
    endtask

    task automatic test_stale_words();
        set_config(256, 128, 2, 1'b1);
        send_pattern(2);
        wait_idle();
        // upper half of the element comes from the previous load
        send_pattern(1);
        wait_idle();
        set_config(1, 1, 1, 1'b1);
        send_word('1, '0, 1'b1);
        wait_idle();
    endtask

    task automatic test_single_bit_element();
        set_config(4096, 1, 4096, 1'b1);
        send_pattern(1);
        wait_idle();
    endtask

    task automatic test_full_store_load();
        // words past the store depth are dropped
        set_config(4096, 4096, 1, 1'b1);
        send_pattern(70);
        wait_idle();
        set_config(8191, 8191, 8191, 1'b1);
        send_pattern(1);
        wait_idle();
    endtask

    task automatic test_backpressure();
        set_config(256, 24, 20, 1'b1);
        tx_burst = 1'b1;
        rx_hold_cycles = LONG_HOLD;
        for (int i = 0; i < 6; i++) send_pattern($urandom_range(1, 3));
        wait_idle();
        tx_burst = 1'b0;
    endtask

    task automatic apply_random_setting();
        int tw, ew, et;
        case ($urandom_range(0, 9))
            0:       tw = 0;
            1:       tw = $urandom_range(4097, 8191);
            2, 3:    tw = $urandom_range(257, 4096);
            default: tw = $urandom_range(1, 256);
        endcase
        case ($urandom_range(0, 9))
            0:       ew = 0;
            1:       ew = $urandom_range(1, 8);
            2:       ew = $urandom_range(4097, 8191);
            3:       ew = $urandom_range(257, 4096);
            default: ew = $urandom_range(9, 256);
        endcase
        // keep narrow elements on short vectors, they cost many segments
        if (tw > 256 && ew != 0 && ew < 32) ew = $urandom_range(32, 256);
        case ($urandom_range(0, 7))
            0:       et = 0;
            1:       et = 8191;
            2:       et = 1;
            default: et = $urandom_range(2, 300);
        endcase
        set_config(tw, ew, et, 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_phases();
        int first_item;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            apply_random_setting();
            repeat ($urandom_range(3, 8)) begin
                case ($urandom_range(0, 9))
                    0:       send_pattern($urandom_range(60, 70));
                    1, 2:    send_pattern($urandom_range(4, 16));
                    default: send_pattern($urandom_range(1, 3));
                endcase
            end
            wait_idle();
        end
        tx_burst = 1'b0;
        rx_burst = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_basic_replicate();
        test_top_word_clear();
        test_unknown_off();
        test_zero_cases();
        test_oversized_width();
        test_stale_words();
        test_single_bit_element();
        test_full_store_load();
        test_backpressure();
        test_random_phases();
        if (fill_words_due.size() != 0) begin
            mismatches++;
            $display("%0t: %0d fill words never arrived", $time, fill_words_due.size());
        end
        $display("Sent %0d pattern words forming %0d loads under %0d register settings;",
                 items_sent, fills_done, settings_used);
        $display("checked %0d fill words, %0d field mismatches.", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
